>>> hdl/tre_pkg.sv
// Shared types, constants and codes of the transfer rate and ETA estimator.
package tre_pkg;

  localparam int unsigned SAMPLE_SLOTS_DEF = 8;
  localparam int unsigned ITER_MUL = 64;
  localparam int unsigned ITER_DIV = 128;
  localparam logic [29:0] NS_PER_S = 30'd1000000000;
  localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
  localparam logic [7:0] WINDOW_RESET = 8'd30;
  localparam logic [31:0] INTERVAL_RESET = 32'd250000000;

  typedef enum logic [1:0] {
    CFG_TOTAL    = 2'd0,
    CFG_WINDOW   = 2'd1,
    CFG_INTERVAL = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0] added_bytes;
    logic [62:0] now_ns;
  } in_item_t;

  typedef struct packed {
    logic [47:0] done_bytes;
    logic [47:0] speed_bps;
    logic [47:0] eta_seconds;
  } out_item_t;

  typedef enum logic [2:0] {
    AR_SPD_MUL,
    AR_SPD_DIV,
    AR_ETA_MUL1,
    AR_ETA_MUL2,
    AR_ETA_DIV,
    AR_FB_DIV
  } arith_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_SPEED,
    ST_SMUL,
    ST_SDIV,
    ST_ETA,
    ST_SCAN,
    ST_SDRAIN,
    ST_EDEC,
    ST_EMUL1,
    ST_EMUL2,
    ST_EDIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic       load_in;
    logic       accum;
    logic       set_base;
    logic       spd_write;
    logic       eta_clear;
    logic       eta_write;
    logic       ring_push;
    logic       scan_step;
    logic       cap_div;
    logic       out_load;
    logic       arith_start;
    arith_sel_e arith_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic added_zero;
    logic spd_due;
    logic base_valid;
    logic eta_zero;
    logic scan_last;
    logic found;
    logic speed_zero;
    logic arith_done;
    logic out_free;
  } dp_stat_t;

endpackage

>>> hdl/transfer_rate_eta_estimator.sv
// Top level of the transfer rate and ETA estimator.
// The input channel carries one progress update per item (added_bytes, now_ns) under
// in_valid_i / in_stall_o; the output channel returns one item per update with the
// done count, the measured speed and the ETA under out_valid_o / out_stall_i.
// The user must write the configuration registers through cfg_we_i, cfg_idx_i and
// cfg_wdata_i only while the block is idle; the block itself does not enforce this.
// One update is handled at a time. An update that adds no bytes skips the arithmetic
// and goes straight to the output register. Otherwise the work is done by one shared
// arithmetic unit, a shift-add multiplier and a restoring divider, plus a ring scan
// of one sample per cycle.
// The next update is taken as soon as the result sits in the output register, even
// if the receiver has not taken it yet. While the receiver stalls, the result holds
// and a following update finishes its work but waits before its result is loaded.
// Reset clears all progress state, empties the ring and restores register defaults.
module transfer_rate_eta_estimator #(
  parameter int unsigned SAMPLE_SLOTS = tre_pkg::SAMPLE_SLOTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tre_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tre_pkg::out_item_t out_item_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [47:0]        cfg_wdata_i
);

  tre_pkg::dp_cmd_t  cmd;
  tre_pkg::dp_stat_t stat;

  tre_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tre_dp #(
    .SAMPLE_SLOTS (SAMPLE_SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

endmodule

>>> hdl/tre_arith.sv
// Shared shift-add multiplier and restoring divider with 48-bit saturating quotient.
module tre_arith (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic         is_div_i,
  input  logic         round_i,
  input  logic [127:0] opa_i,
  input  logic [127:0] opb_i,
  output logic         busy_o,
  output logic [127:0] prod_o,
  output logic [47:0]  quot_o
);

  logic [127:0] acc_q, acc_d, x_q, x_d, y_q, y_d, z_q, z_d;
  logic [7:0]   cnt_q, cnt_d;
  logic         div_q, div_d, round_q, round_d;
  logic [127:0] r2;
  logic         ge;
  logic [128:0] q_inc;

  always_comb begin
    acc_d   = acc_q;
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    cnt_d   = cnt_q;
    div_d   = div_q;
    round_d = round_q;
    r2      = {acc_q[126:0], x_q[127]};
    ge      = (r2 >= z_q);
    if (start_i) begin
      acc_d   = '0;
      x_d     = opa_i;
      y_d     = '0;
      z_d     = opb_i;
      cnt_d   = is_div_i ? 8'(tre_pkg::ITER_DIV) : 8'(tre_pkg::ITER_MUL);
      div_d   = is_div_i;
      round_d = round_i;
    end else if (cnt_q != 8'd0) begin
      cnt_d = cnt_q - 8'd1;
      x_d   = {x_q[126:0], 1'b0};
      if (div_q) begin
        acc_d = ge ? (r2 - z_q) : r2;
        y_d   = {y_q[126:0], ge};
      end else begin
        if (z_q[0]) begin
          acc_d = acc_q + x_q;
        end
        z_d = {1'b0, z_q[127:1]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    x_q     <= x_d;
    y_q     <= y_d;
    z_q     <= z_d;
    div_q   <= div_d;
    round_q <= round_d;
  end

  assign q_inc  = {1'b0, y_q} + 129'(round_q && (acc_q != '0));
  assign quot_o = (q_inc[128:48] != '0) ? tre_pkg::MAX48 : q_inc[47:0];
  assign prod_o = acc_q;
  assign busy_o = (cnt_q != 8'd0);

endmodule

>>> hdl/tre_dp.sv
// Datapath: configuration, progress state, sample ring, arithmetic and result register.
module tre_dp #(
  parameter int unsigned SAMPLE_SLOTS = tre_pkg::SAMPLE_SLOTS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tre_pkg::dp_cmd_t    cmd_i,
  output tre_pkg::dp_stat_t   stat_o,
  input  tre_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tre_pkg::out_item_t  out_item_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [47:0]         cfg_wdata_i
);

  localparam int unsigned IDXW = $clog2(SAMPLE_SLOTS);
  localparam int unsigned CNTW = $clog2(SAMPLE_SLOTS + 1);

  logic [47:0] total_q;
  logic [7:0]  window_q;
  logic [31:0] interval_q;
  logic [37:0] limit_q;

  logic [31:0] added_q;
  logic [62:0] now_q;
  logic [47:0] done_q, speed_q, base_done_q, eta_q;
  logic [62:0] base_time_q;
  logic        base_valid_q;
  logic [IDXW-1:0] ring_next_q, scan_idx_q;
  logic [CNTW-1:0] ring_count_q;
  logic        found_q, rd_v_q, out_valid_q;
  logic [62:0] best_age_q;
  logic [47:0] best_done_q;
  logic [127:0] divisor_q;
  tre_pkg::out_item_t out_item_q;

  logic [47:0] ring_done_mem [SAMPLE_SLOTS];
  logic [62:0] ring_time_mem [SAMPLE_SLOTS];
  logic [47:0] rd_done_q;
  logic [62:0] rd_time_q;

  logic [48:0]  sum;
  logic [47:0]  done_next;
  logic [62:0]  elapsed, age;
  logic [47:0]  spd_delta, remaining;
  logic         cand;
  logic         ar_busy, ar_div, ar_round;
  logic [127:0] ar_a, ar_b, ar_prod;
  logic [47:0]  ar_quot;

  always_comb begin
    sum = {1'b0, done_q} + 49'(added_q);
    if (total_q != '0) begin
      done_next = (sum > {1'b0, total_q}) ? total_q : sum[47:0];
    end else begin
      done_next = (sum[48]) ? tre_pkg::MAX48 : sum[47:0];
    end
  end

  assign elapsed   = now_q - base_time_q;
  assign spd_delta = (done_q >= base_done_q) ? (done_q - base_done_q) : '0;
  assign remaining = total_q - done_q;
  assign age       = now_q - rd_time_q;
  assign cand      = !(rd_done_q >= done_q) && !(rd_time_q >= now_q)
                     && (age <= 63'(limit_q)) && (!found_q || (age > best_age_q));

  always_comb begin
    ar_a     = '0;
    ar_b     = '0;
    ar_div   = 1'b0;
    ar_round = 1'b0;
    unique case (cmd_i.arith_sel)
      tre_pkg::AR_SPD_MUL: begin
        ar_a = 128'(spd_delta);
        ar_b = 128'(tre_pkg::NS_PER_S);
      end
      tre_pkg::AR_SPD_DIV: begin
        ar_a   = ar_prod;
        ar_b   = 128'(elapsed);
        ar_div = 1'b1;
      end
      tre_pkg::AR_ETA_MUL1: begin
        ar_a = 128'(done_q - best_done_q);
        ar_b = 128'(tre_pkg::NS_PER_S);
      end
      tre_pkg::AR_ETA_MUL2: begin
        ar_a = 128'(remaining);
        ar_b = 128'(best_age_q);
      end
      tre_pkg::AR_ETA_DIV: begin
        ar_a     = ar_prod;
        ar_b     = divisor_q;
        ar_div   = 1'b1;
        ar_round = 1'b1;
      end
      tre_pkg::AR_FB_DIV: begin
        ar_a     = 128'(remaining);
        ar_b     = 128'(speed_q);
        ar_div   = 1'b1;
        ar_round = 1'b1;
      end
      default: begin
        ar_a = '0;
      end
    endcase
  end

  tre_arith u_arith (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.arith_start),
    .is_div_i (ar_div),
    .round_i  (ar_round),
    .opa_i    (ar_a),
    .opb_i    (ar_b),
    .busy_o   (ar_busy),
    .prod_o   (ar_prod),
    .quot_o   (ar_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q      <= '0;
      window_q     <= tre_pkg::WINDOW_RESET;
      interval_q   <= tre_pkg::INTERVAL_RESET;
      done_q       <= '0;
      speed_q      <= '0;
      base_done_q  <= '0;
      base_time_q  <= '0;
      base_valid_q <= 1'b0;
      ring_next_q  <= '0;
      ring_count_q <= '0;
      eta_q        <= '0;
      scan_idx_q   <= '0;
      found_q      <= 1'b0;
      rd_v_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          tre_pkg::CFG_TOTAL:    total_q    <= cfg_wdata_i;
          tre_pkg::CFG_WINDOW:   window_q   <= cfg_wdata_i[7:0];
          tre_pkg::CFG_INTERVAL: interval_q <= cfg_wdata_i[31:0];
          default: ;
        endcase
      end
      if (cmd_i.accum) begin
        done_q <= done_next;
      end
      if (cmd_i.set_base) begin
        base_done_q  <= done_q;
        base_time_q  <= now_q;
        base_valid_q <= 1'b1;
      end
      if (cmd_i.spd_write) begin
        speed_q     <= ar_quot;
        base_done_q <= done_q;
        base_time_q <= now_q;
      end
      if (cmd_i.eta_clear) begin
        eta_q <= '0;
      end else if (cmd_i.eta_write) begin
        eta_q <= ar_quot;
      end
      if (cmd_i.ring_push) begin
        ring_next_q <= (ring_next_q == IDXW'(SAMPLE_SLOTS - 1)) ? '0 : ring_next_q + 1'b1;
        if (ring_count_q != CNTW'(SAMPLE_SLOTS)) begin
          ring_count_q <= ring_count_q + 1'b1;
        end
        scan_idx_q <= '0;
        found_q    <= 1'b0;
      end else begin
        if (cmd_i.scan_step) begin
          scan_idx_q <= scan_idx_q + 1'b1;
        end
        if (rd_v_q && cand) begin
          found_q <= 1'b1;
        end
      end
      rd_v_q <= cmd_i.scan_step;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    limit_q <= 38'(window_q) * 38'(tre_pkg::NS_PER_S);
    if (cmd_i.load_in) begin
      added_q <= in_item_i.added_bytes;
      now_q   <= in_item_i.now_ns;
    end
    if (rd_v_q && cand) begin
      best_age_q  <= age;
      best_done_q <= rd_done_q;
    end
    if (cmd_i.cap_div) begin
      divisor_q <= ar_prod;
    end
    if (cmd_i.out_load) begin
      out_item_q <= '{done_bytes: done_q, speed_bps: speed_q, eta_seconds: eta_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ring_push) begin
      ring_done_mem[ring_next_q] <= done_q;
      ring_time_mem[ring_next_q] <= now_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_done_q <= ring_done_mem[scan_idx_q];
    rd_time_q <= ring_time_mem[scan_idx_q];
  end

  assign stat_o.added_zero = (added_q == '0);
  assign stat_o.spd_due    = base_valid_q && (now_q >= base_time_q)
                             && (elapsed >= 63'(interval_q)) && (elapsed != '0);
  assign stat_o.base_valid = base_valid_q;
  assign stat_o.eta_zero   = (total_q == '0) || (done_q == '0) || (done_q >= total_q);
  assign stat_o.scan_last  = (CNTW'(scan_idx_q) == (ring_count_q - CNTW'(1)));
  assign stat_o.found      = found_q;
  assign stat_o.speed_zero = (speed_q == '0);
  assign stat_o.arith_done = !ar_busy;
  assign stat_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

>>> hdl/tre_ctrl.sv
// Controller state machine that sequences the datapath for one item at a time.
module tre_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tre_pkg::dp_stat_t stat_i,
  output tre_pkg::dp_cmd_t  cmd_o
);

  tre_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tre_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tre_pkg::ST_IDLE:   if (in_valid_i) state_d = tre_pkg::ST_ACCUM;
      tre_pkg::ST_ACCUM:  state_d = stat_i.added_zero ? tre_pkg::ST_OUT : tre_pkg::ST_SPEED;
      tre_pkg::ST_SPEED:  state_d = stat_i.spd_due ? tre_pkg::ST_SMUL : tre_pkg::ST_ETA;
      tre_pkg::ST_SMUL:   if (stat_i.arith_done) state_d = tre_pkg::ST_SDIV;
      tre_pkg::ST_SDIV:   if (stat_i.arith_done) state_d = tre_pkg::ST_ETA;
      tre_pkg::ST_ETA:    state_d = stat_i.eta_zero ? tre_pkg::ST_OUT : tre_pkg::ST_SCAN;
      tre_pkg::ST_SCAN:   if (stat_i.scan_last) state_d = tre_pkg::ST_SDRAIN;
      tre_pkg::ST_SDRAIN: state_d = tre_pkg::ST_EDEC;
      tre_pkg::ST_EDEC: begin
        if (stat_i.found) begin
          state_d = tre_pkg::ST_EMUL1;
        end else if (stat_i.speed_zero) begin
          state_d = tre_pkg::ST_OUT;
        end else begin
          state_d = tre_pkg::ST_EDIV;
        end
      end
      tre_pkg::ST_EMUL1:  if (stat_i.arith_done) state_d = tre_pkg::ST_EMUL2;
      tre_pkg::ST_EMUL2:  if (stat_i.arith_done) state_d = tre_pkg::ST_EDIV;
      tre_pkg::ST_EDIV:   if (stat_i.arith_done) state_d = tre_pkg::ST_OUT;
      tre_pkg::ST_OUT:    if (stat_i.out_free) state_d = tre_pkg::ST_IDLE;
      default:            state_d = tre_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      tre_pkg::ST_IDLE:  cmd_o.load_in = in_valid_i;
      tre_pkg::ST_ACCUM: cmd_o.accum = !stat_i.added_zero;
      tre_pkg::ST_SPEED: begin
        if (stat_i.spd_due) begin
          cmd_o.arith_start = 1'b1;
          cmd_o.arith_sel   = tre_pkg::AR_SPD_MUL;
        end else begin
          cmd_o.set_base = !stat_i.base_valid;
        end
      end
      tre_pkg::ST_SMUL: begin
        cmd_o.arith_start = stat_i.arith_done;
        cmd_o.arith_sel   = tre_pkg::AR_SPD_DIV;
      end
      tre_pkg::ST_SDIV:  cmd_o.spd_write = stat_i.arith_done;
      tre_pkg::ST_ETA: begin
        cmd_o.eta_clear = stat_i.eta_zero;
        cmd_o.ring_push = !stat_i.eta_zero;
      end
      tre_pkg::ST_SCAN:  cmd_o.scan_step = 1'b1;
      tre_pkg::ST_SDRAIN: ;
      tre_pkg::ST_EDEC: begin
        if (stat_i.found) begin
          cmd_o.arith_start = 1'b1;
          cmd_o.arith_sel   = tre_pkg::AR_ETA_MUL1;
        end else if (stat_i.speed_zero) begin
          cmd_o.eta_clear = 1'b1;
        end else begin
          cmd_o.arith_start = 1'b1;
          cmd_o.arith_sel   = tre_pkg::AR_FB_DIV;
        end
      end
      tre_pkg::ST_EMUL1: begin
        cmd_o.cap_div     = stat_i.arith_done;
        cmd_o.arith_start = stat_i.arith_done;
        cmd_o.arith_sel   = tre_pkg::AR_ETA_MUL2;
      end
      tre_pkg::ST_EMUL2: begin
        cmd_o.arith_start = stat_i.arith_done;
        cmd_o.arith_sel   = tre_pkg::AR_ETA_DIV;
      end
      tre_pkg::ST_EDIV:  cmd_o.eta_write = stat_i.arith_done;
      tre_pkg::ST_OUT:   cmd_o.out_load = stat_i.out_free;
      default: ;
    endcase
  end

  assign in_stall_o = (state_q != tre_pkg::ST_IDLE);

endmodule

>>> hdl/tre_chk.sv
// Port-level checker of the transfer rate and ETA estimator and its bind.
module tre_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input tre_pkg::out_item_t out_item_o
);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("Input was not stalled after an item was accepted.");

  a_eta_zero_when_nothing_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_item_o.done_bytes == '0)) |-> (out_item_o.eta_seconds == '0))
    else $error("Nonzero ETA reported with nothing done.");

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("Output valid dropped while stalled.");

  a_out_item_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(out_item_o))
    else $error("Output item changed while stalled.");

endmodule

bind transfer_rate_eta_estimator tre_chk u_tre_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
